// ----- sv/dtiu_pkg.sv -----
// package for the data transfer instruction unit
// types, opcodes, register codes and register file helpers; no dependencies
package dtiu_pkg;

    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    typedef logic [ADDR_BITS-1:0] addr_t;

    typedef enum logic [3:0] {
        OP_MOV  = 4'd0,
        OP_MVI  = 4'd1,
        OP_LXI  = 4'd2,
        OP_LDA  = 4'd3,
        OP_STA  = 4'd4,
        OP_LHLD = 4'd5,
        OP_SHLD = 4'd6,
        OP_STAX = 4'd7,
        OP_XCHG = 4'd8,
        OP_SET  = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_REG  = 2'd1,
        ERR_PAIR = 2'd2,
        ERR_DATA = 2'd3
    } err_t;

    localparam logic [2:0] REG_B = 3'd0;
    localparam logic [2:0] REG_C = 3'd1;
    localparam logic [2:0] REG_D = 3'd2;
    localparam logic [2:0] REG_E = 3'd3;
    localparam logic [2:0] REG_H = 3'd4;
    localparam logic [2:0] REG_L = 3'd5;
    localparam logic [2:0] REG_M = 3'd6;
    localparam logic [2:0] REG_A = 3'd7;

    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_NONE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_LO,
        ST_RD_HI,
        ST_WR_HI
    } state_t;

    typedef struct packed {
        logic [3:0]  mode;
        logic [2:0]  dst_reg;
        logic [2:0]  src_reg;
        logic [1:0]  reg_pair;
        logic [15:0] immediate;
        logic [15:0] address;
    } cmd_t;

    typedef struct packed {
        logic [1:0] error_code;
        logic [7:0] acc_out;
        logic [7:0] b_out;
        logic [7:0] c_out;
        logic [7:0] d_out;
        logic [7:0] e_out;
        logic [7:0] h_out;
        logic [7:0] l_out;
    } res_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        logic [7:0] e;
        logic [7:0] h;
        logic [7:0] l;
    } regs_t;

    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        addr_t      addr;
        logic [7:0] wdata;
    } mem_req_t;

    function automatic logic [7:0] get_reg(regs_t r, logic [2:0] code);
        logic [7:0] v;
        case (code)
            REG_B:   v = r.b;
            REG_C:   v = r.c;
            REG_D:   v = r.d;
            REG_E:   v = r.e;
            REG_H:   v = r.h;
            REG_L:   v = r.l;
            REG_A:   v = r.a;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic regs_t set_reg(regs_t r, logic [2:0] code, logic [7:0] v);
        regs_t n;
        n = r;
        case (code)
            REG_B:   n.b = v;
            REG_C:   n.c = v;
            REG_D:   n.d = v;
            REG_E:   n.e = v;
            REG_H:   n.h = v;
            REG_L:   n.l = v;
            REG_A:   n.a = v;
            default: n = r;
        endcase
        return n;
    endfunction

    function automatic addr_t to_addr(logic [7:0] hi, logic [7:0] lo);
        logic [15:0] w;
        w = {hi, lo};
        return w[ADDR_BITS-1:0];
    endfunction

endpackage

// ----- sv/dtiu_mem.sv -----
// single-port byte data memory with registered read
// depends on dtiu_pkg
module dtiu_mem (
    input  logic              clk,
    input  dtiu_pkg::mem_req_t req,
    output logic [7:0]        rdata
);
    import dtiu_pkg::*;

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/dtiu_seq.sv -----
// instruction sequencer with register file: decodes, drives the memory
// and builds the result transaction; depends on dtiu_pkg
module dtiu_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  dtiu_pkg::cmd_t     cmd,
    output dtiu_pkg::mem_req_t mem_req,
    input  logic [7:0]         mem_rdata,
    input  logic               res_free,
    output logic               res_load,
    output dtiu_pkg::res_t     res_next
);
    import dtiu_pkg::*;

    state_t state_reg, state_next;
    cmd_t   inst_reg;
    regs_t  rf_reg, rf_next, rf_work;
    err_t   err;
    logic   finish;
    addr_t  addr_d, addr_n, hl_addr, pair_addr;
    logic   imm_ok;
    mem_req_t req_work;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rf_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rf_reg    <= rf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            inst_reg <= cmd;
        end
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign addr_d    = inst_reg.address[ADDR_BITS-1:0];
    assign addr_n    = addr_d + addr_t'(1);
    assign hl_addr   = to_addr(rf_reg.h, rf_reg.l);
    assign imm_ok    = (inst_reg.immediate[15:8] == 8'h00);

    always_comb
    begin
        case (inst_reg.reg_pair)
            PAIR_BC: pair_addr = to_addr(rf_reg.b, rf_reg.c);
            PAIR_DE: pair_addr = to_addr(rf_reg.d, rf_reg.e);
            default: pair_addr = hl_addr;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        rf_work    = rf_reg;
        req_work   = '0;
        err        = ERR_OK;
        finish     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (inst_reg.mode)
                    OP_MOV:
                    begin
                        if (inst_reg.dst_reg == REG_M && inst_reg.src_reg == REG_M)
                        begin
                            err    = ERR_REG;
                            finish = 1'b1;
                        end
                        else if (inst_reg.src_reg == REG_M)
                        begin
                            req_work.rd_en = 1'b1;
                            req_work.addr  = hl_addr;
                            state_next     = ST_RD_LO;
                        end
                        else if (inst_reg.dst_reg == REG_M)
                        begin
                            req_work.wr_en = 1'b1;
                            req_work.addr  = hl_addr;
                            req_work.wdata = get_reg(rf_reg, inst_reg.src_reg);
                            finish         = 1'b1;
                        end
                        else
                        begin
                            rf_work = set_reg(rf_reg, inst_reg.dst_reg,
                                              get_reg(rf_reg, inst_reg.src_reg));
                            finish  = 1'b1;
                        end
                    end
                    OP_MVI:
                    begin
                        finish = 1'b1;
                        if (!imm_ok)
                        begin
                            err = ERR_DATA;
                        end
                        else if (inst_reg.dst_reg == REG_M)
                        begin
                            req_work.wr_en = 1'b1;
                            req_work.addr  = hl_addr;
                            req_work.wdata = inst_reg.immediate[7:0];
                        end
                        else
                        begin
                            rf_work = set_reg(rf_reg, inst_reg.dst_reg,
                                              inst_reg.immediate[7:0]);
                        end
                    end
                    OP_LXI:
                    begin
                        finish = 1'b1;
                        case (inst_reg.reg_pair)
                            PAIR_BC:
                            begin
                                rf_work.b = inst_reg.immediate[15:8];
                                rf_work.c = inst_reg.immediate[7:0];
                            end
                            PAIR_DE:
                            begin
                                rf_work.d = inst_reg.immediate[15:8];
                                rf_work.e = inst_reg.immediate[7:0];
                            end
                            PAIR_HL:
                            begin
                                rf_work.h = inst_reg.immediate[15:8];
                                rf_work.l = inst_reg.immediate[7:0];
                            end
                            default: err = ERR_PAIR;
                        endcase
                    end
                    OP_LDA, OP_LHLD:
                    begin
                        req_work.rd_en = 1'b1;
                        req_work.addr  = addr_d;
                        state_next     = ST_RD_LO;
                    end
                    OP_STA:
                    begin
                        req_work.wr_en = 1'b1;
                        req_work.addr  = addr_d;
                        req_work.wdata = rf_reg.a;
                        finish         = 1'b1;
                    end
                    OP_SHLD:
                    begin
                        req_work.wr_en = 1'b1;
                        req_work.addr  = addr_d;
                        req_work.wdata = rf_reg.l;
                        state_next     = ST_WR_HI;
                    end
                    OP_STAX:
                    begin
                        finish = 1'b1;
                        if (inst_reg.reg_pair == PAIR_NONE)
                        begin
                            err = ERR_PAIR;
                        end
                        else
                        begin
                            req_work.wr_en = 1'b1;
                            req_work.addr  = pair_addr;
                            req_work.wdata = rf_reg.a;
                        end
                    end
                    OP_XCHG:
                    begin
                        rf_work.h = rf_reg.d;
                        rf_work.d = rf_reg.h;
                        rf_work.l = rf_reg.e;
                        rf_work.e = rf_reg.l;
                        finish    = 1'b1;
                    end
                    OP_SET:
                    begin
                        finish = 1'b1;
                        if (!imm_ok)
                        begin
                            err = ERR_DATA;
                        end
                        else
                        begin
                            req_work.wr_en = 1'b1;
                            req_work.addr  = addr_d;
                            req_work.wdata = inst_reg.immediate[7:0];
                        end
                    end
                    default:
                    begin
                        err    = ERR_DATA;
                        finish = 1'b1;
                    end
                endcase
            end
            ST_RD_LO:
            begin
                if (inst_reg.mode == OP_LHLD)
                begin
                    rf_work.l      = mem_rdata;
                    req_work.rd_en = 1'b1;
                    req_work.addr  = addr_n;
                    state_next     = ST_RD_HI;
                end
                else if (inst_reg.mode == OP_LDA)
                begin
                    rf_work.a = mem_rdata;
                    finish    = 1'b1;
                end
                else
                begin
                    rf_work = set_reg(rf_reg, inst_reg.dst_reg, mem_rdata);
                    finish  = 1'b1;
                end
            end
            ST_RD_HI:
            begin
                rf_work.h = mem_rdata;
                finish    = 1'b1;
            end
            ST_WR_HI:
            begin
                req_work.wr_en = 1'b1;
                req_work.addr  = addr_n;
                req_work.wdata = rf_reg.h;
                finish         = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hold the final step until the result register can take it
        rf_next  = rf_work;
        mem_req  = req_work;
        res_load = 1'b0;
        if (finish)
        begin
            if (res_free)
            begin
                res_load   = 1'b1;
                state_next = ST_IDLE;
            end
            else
            begin
                rf_next       = rf_reg;
                mem_req.wr_en = 1'b0;
            end
        end
    end

    assign res_next.error_code = err;
    assign res_next.acc_out    = rf_work.a;
    assign res_next.b_out      = rf_work.b;
    assign res_next.c_out      = rf_work.c;
    assign res_next.d_out      = rf_work.d;
    assign res_next.e_out      = rf_work.e;
    assign res_next.h_out      = rf_work.h;
    assign res_next.l_out      = rf_work.l;

endmodule

// ----- sv/data_transfer_instruction_unit.sv -----
// top level of the data transfer instruction unit: sequencer, data memory
// and result register; depends on dtiu_pkg, dtiu_mem and dtiu_seq
//
// one command transaction is taken at a time and gives one result transaction
// with the error code and all seven registers after the instruction. register
// moves, immediates, exchanges, stores and error cases finish in ST_EXEC;
// LDA and MOV r,M add ST_RD_LO, SHLD adds ST_WR_HI and LHLD adds ST_RD_LO and
// ST_RD_HI. the steps are set by the single-port data memory with its registered
// read: each memory access of an instruction is one sequencer step. the result
// register lets the next command start while a result waits to be taken.
// data memory has no reset; a location must be written before it is read.
module data_transfer_instruction_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  dtiu_pkg::cmd_t  cmd,
    output logic            res_valid,
    input  logic            res_stall,
    output dtiu_pkg::res_t  res
);
    import dtiu_pkg::*;

    mem_req_t   mem_req;
    logic [7:0] mem_rdata;
    logic       res_free;
    logic       res_load;
    res_t       res_next;
    logic       res_valid_reg;
    res_t       res_reg;

    dtiu_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_free  (res_free),
        .res_load  (res_load),
        .res_next  (res_next)
    );

    dtiu_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign res_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!res_valid_reg || !res_stall))
        else $error("result register overwritten while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("command accepted while another is in progress");

    a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("memory read and write in the same cycle");

    a_idle_no_access: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_stall |-> (!mem_req.rd_en && !mem_req.wr_en && !res_load))
        else $error("memory access or result while idle");

endmodule

// ----- sim/testbench.sv -----
// testbench for data_transfer_instruction_unit: directed table, then random instruction mix
// depends on dtiu_pkg and the unit's rtl; checked against set values or in-bench predictor
module testbench;
    import dtiu_pkg::*;

    localparam logic [3:0] MODE_BAD_LO = 4'd10;
    localparam logic [3:0] MODE_BAD_HI = 4'd15;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        cmd_t c;
        bit   chk;
        res_t want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    logic [7:0] gpr [8];
    logic [7:0] mem_img [MEM_DEPTH];
    bit mem_known [MEM_DEPTH];
    res_t pending_results [$];
    step_t plan [$];
    int unsigned mismatches = 0;
    int unsigned stall_left = 0;
    bit calm = 1'b0;
    res_t got_want;

    data_transfer_instruction_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #15000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic void mem_put(addr_t a, logic [7:0] v);
        mem_img[a] = v;
        mem_known[a] = 1'b1;
    endfunction

    // executes one instruction on the predictor state and returns the result transaction
    function automatic res_t run_instr(cmd_t c);
        addr_t a;
        addr_t a1;
        addr_t hl;
        logic [1:0] err;
        logic [7:0] t;
        res_t r;
        a = c.address[ADDR_BITS-1:0];
        a1 = a + 1'b1;
        hl = addr_t'({gpr[REG_H], gpr[REG_L]});
        err = ERR_OK;
        case (c.mode)
            OP_MOV:
                if (c.dst_reg == REG_M && c.src_reg == REG_M)
                    err = ERR_REG;
                else if (c.src_reg == REG_M)
                    gpr[c.dst_reg] = mem_img[hl];
                else if (c.dst_reg == REG_M)
                    mem_put(hl, gpr[c.src_reg]);
                else
                    gpr[c.dst_reg] = gpr[c.src_reg];
            OP_MVI:
                if (c.immediate[15:8] != 8'h00)
                    err = ERR_DATA;
                else if (c.dst_reg == REG_M)
                    mem_put(hl, c.immediate[7:0]);
                else
                    gpr[c.dst_reg] = c.immediate[7:0];
            OP_LXI:
                if (c.reg_pair == PAIR_NONE)
                    err = ERR_PAIR;
                else
                begin
                    gpr[{c.reg_pair, 1'b0}] = c.immediate[15:8];
                    gpr[{c.reg_pair, 1'b1}] = c.immediate[7:0];
                end
            OP_LDA:
                gpr[REG_A] = mem_img[a];
            OP_STA:
                mem_put(a, gpr[REG_A]);
            OP_LHLD:
            begin
                gpr[REG_L] = mem_img[a];
                gpr[REG_H] = mem_img[a1];
            end
            OP_SHLD:
            begin
                mem_put(a, gpr[REG_L]);
                mem_put(a1, gpr[REG_H]);
            end
            OP_STAX:
                if (c.reg_pair == PAIR_NONE)
                    err = ERR_PAIR;
                else
                    mem_put(addr_t'({gpr[{c.reg_pair, 1'b0}], gpr[{c.reg_pair, 1'b1}]}),
                            gpr[REG_A]);
            OP_XCHG:
            begin
                t = gpr[REG_H];
                gpr[REG_H] = gpr[REG_D];
                gpr[REG_D] = t;
                t = gpr[REG_L];
                gpr[REG_L] = gpr[REG_E];
                gpr[REG_E] = t;
            end
            OP_SET:
                if (c.immediate[15:8] != 8'h00)
                    err = ERR_DATA;
                else
                    mem_put(a, c.immediate[7:0]);
            default:
                err = ERR_DATA;
        endcase
        r.error_code = err;
        r.acc_out = gpr[REG_A];
        r.b_out = gpr[REG_B];
        r.c_out = gpr[REG_C];
        r.d_out = gpr[REG_D];
        r.e_out = gpr[REG_E];
        r.h_out = gpr[REG_H];
        r.l_out = gpr[REG_L];
        return r;
    endfunction

    function automatic logic [15:0] pick_addr();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return 16'($urandom_range(15));
        if (r < 60)
            return 16'(16'hFFF0 + $urandom_range(15));
        if (r < 80)
            return 16'(16'h5A30 + $urandom_range(15));
        return 16'($urandom);
    endfunction

    // random instruction; a read of memory never written is turned into the matching write
    function automatic cmd_t draw_instr();
        cmd_t c;
        int unsigned r;
        addr_t a;
        addr_t hl;
        r = $urandom_range(99);
        if (r < 20)
            c.mode = OP_MOV;
        else if (r < 32)
            c.mode = OP_MVI;
        else if (r < 44)
            c.mode = OP_LXI;
        else if (r < 52)
            c.mode = OP_LDA;
        else if (r < 60)
            c.mode = OP_STA;
        else if (r < 67)
            c.mode = OP_LHLD;
        else if (r < 74)
            c.mode = OP_SHLD;
        else if (r < 81)
            c.mode = OP_STAX;
        else if (r < 87)
            c.mode = OP_XCHG;
        else if (r < 95)
            c.mode = OP_SET;
        else
            c.mode = 4'($urandom_range(MODE_BAD_HI, MODE_BAD_LO));
        c.dst_reg = 3'($urandom_range(7));
        c.src_reg = 3'($urandom_range(7));
        c.reg_pair = ($urandom_range(99) < 85) ? 2'($urandom_range(2)) : PAIR_NONE;
        c.address = pick_addr();
        if (c.mode == OP_LXI)
            c.immediate = ($urandom_range(99) < 60) ? pick_addr() : 16'($urandom);
        else if ($urandom_range(99) < 90)
            c.immediate = 16'($urandom_range(255));
        else
            c.immediate = 16'($urandom_range(65535, 256));
        a = c.address[ADDR_BITS-1:0];
        hl = addr_t'({gpr[REG_H], gpr[REG_L]});
        case (c.mode)
            OP_MOV:
                if (c.src_reg == REG_M && c.dst_reg != REG_M && !mem_known[hl])
                begin
                    c.src_reg = c.dst_reg;
                    c.dst_reg = REG_M;
                end
            OP_LDA:
                if (!mem_known[a])
                    c.mode = OP_STA;
            OP_LHLD:
                if (!mem_known[a] || !mem_known[addr_t'(a + 1'b1)])
                    c.mode = OP_SHLD;
            default:
                ;
        endcase
        return c;
    endfunction

    function automatic void add_row(cmd_t c, bit chk, res_t want);
        step_t s;
        s.c = c;
        s.chk = chk;
        s.want = want;
        plan.push_back(s);
    endfunction

    task automatic issue(cmd_t c, res_t want);
        int unsigned gap;
        pending_results.push_back(want);
        gap = calm ? 0 : gap_len();
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            res_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_stall <= 1'b0;
            stall_left <= calm ? 0 : gap_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual %p", $time, res);
                mismatches++;
            end
            else
            begin
                got_want = pending_results.pop_front();
                check_field("error_code", 8'(got_want.error_code), 8'(res.error_code));
                check_field("acc_out", got_want.acc_out, res.acc_out);
                check_field("b_out", got_want.b_out, res.b_out);
                check_field("c_out", got_want.c_out, res.c_out);
                check_field("d_out", got_want.d_out, res.d_out);
                check_field("e_out", got_want.e_out, res.e_out);
                check_field("h_out", got_want.h_out, res.h_out);
                check_field("l_out", got_want.l_out, res.l_out);
            end
        end
    end

    initial
    begin
        res_t pred;
        cmd_t c;
        foreach (gpr[i])
            gpr[i] = 8'h00;

        add_row(cmd_t'{OP_MOV, REG_B, REG_C, PAIR_BC, 16'h0000, 16'h0000}, 1'b1,
                res_t'{ERR_OK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        add_row(cmd_t'{OP_MVI, REG_A, REG_B, PAIR_BC, 16'h00FF, 16'h0000}, 1'b1,
                res_t'{ERR_OK, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        add_row(cmd_t'{OP_MVI, REG_B, REG_A, PAIR_BC, 16'h0100, 16'h0000}, 1'b1,
                res_t'{ERR_DATA, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        add_row(cmd_t'{OP_LXI, REG_B, REG_B, PAIR_BC, 16'hFFFF, 16'hFFFF}, 1'b1,
                res_t'{ERR_OK, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        add_row(cmd_t'{OP_LXI, REG_B, REG_B, PAIR_NONE, 16'h1234, 16'h0000}, 1'b1,
                res_t'{ERR_PAIR, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        add_row(cmd_t'{MODE_BAD_HI, REG_A, REG_A, PAIR_NONE, 16'hFFFF, 16'hFFFF}, 1'b1,
                res_t'{ERR_DATA, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        add_row(cmd_t'{OP_MOV, REG_M, REG_M, PAIR_BC, 16'h0000, 16'h0000}, 1'b1,
                res_t'{ERR_REG, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        add_row(cmd_t'{OP_LXI, REG_B, REG_B, PAIR_HL, 16'h0000, 16'h0000}, 1'b0, '0);
        add_row(cmd_t'{OP_MVI, REG_M, REG_B, PAIR_BC, 16'h005A, 16'h0000}, 1'b0, '0);
        add_row(cmd_t'{OP_MOV, REG_D, REG_M, PAIR_BC, 16'h0000, 16'h0000}, 1'b0, '0);
        add_row(cmd_t'{OP_MOV, REG_M, REG_A, PAIR_BC, 16'h0000, 16'h0000}, 1'b0, '0);
        add_row(cmd_t'{OP_SET, REG_B, REG_B, PAIR_BC, 16'h0000, 16'hFFFF}, 1'b0, '0);
        add_row(cmd_t'{OP_SET, REG_B, REG_B, PAIR_BC, 16'hFFFF, 16'h8000}, 1'b0, '0);
        add_row(cmd_t'{OP_SHLD, REG_B, REG_B, PAIR_BC, 16'h0000, 16'hFFFF}, 1'b0, '0);
        add_row(cmd_t'{OP_LHLD, REG_B, REG_B, PAIR_BC, 16'h0000, 16'hFFFF}, 1'b0, '0);
        add_row(cmd_t'{OP_STA, REG_B, REG_B, PAIR_BC, 16'h0000, 16'h8000}, 1'b0, '0);
        add_row(cmd_t'{OP_LDA, REG_B, REG_B, PAIR_BC, 16'h0000, 16'h8000}, 1'b0, '0);
        add_row(cmd_t'{OP_LXI, REG_B, REG_B, PAIR_DE, 16'h8001, 16'h0000}, 1'b0, '0);
        add_row(cmd_t'{OP_STAX, REG_B, REG_B, PAIR_DE, 16'h0000, 16'h0000}, 1'b0, '0);
        add_row(cmd_t'{OP_STAX, REG_B, REG_B, PAIR_NONE, 16'h0000, 16'h0000}, 1'b0, '0);
        add_row(cmd_t'{OP_XCHG, REG_B, REG_B, PAIR_BC, 16'h0000, 16'h0000}, 1'b0, '0);
        add_row(cmd_t'{OP_LDA, REG_B, REG_B, PAIR_BC, 16'h0000, 16'hFFFF}, 1'b0, '0);
        add_row(cmd_t'{MODE_BAD_LO, REG_B, REG_B, PAIR_BC, 16'h0000, 16'h0000}, 1'b0, '0);
        add_row(cmd_t'{OP_MVI, REG_M, REG_B, PAIR_BC, 16'h00FF, 16'h0000}, 1'b0, '0);
        add_row(cmd_t'{OP_MOV, REG_A, REG_M, PAIR_BC, 16'h0000, 16'h0000}, 1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            pred = run_instr(plan[i].c);
            issue(plan[i].c, plan[i].chk ? plan[i].want : pred);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // every fourth stretch runs with no gaps on either side
            calm = ((n / 250) % 4) == 3;
            c = draw_instr();
            pred = run_instr(c);
            issue(c, pred);
        end
        calm = 1'b0;
        cmd_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ----- data_transfer_instruction_unit.f -----
sv/dtiu_pkg.sv
sv/dtiu_mem.sv
sv/dtiu_seq.sv
sv/data_transfer_instruction_unit.sv
sim/testbench.sv
